[design/cc20_pkg.sv]
// cc20_pkg: shared types, constants and the quarter-round function
// for the chacha20 stream cipher block
// depends on nothing; imported by every design file
package cc20_pkg;

  localparam int QR_UNITS_DEF = 4;

  localparam int WORD_W     = 32;
  localparam int WORDS      = 16;
  localparam int POS_W      = 4;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ROUNDS     = 20;
  localparam int SLOT_W     = 2;

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646E;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2D32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6B20_6574;

  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  localparam logic [POS_W-1:0] POS_LAST = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_1  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  // controller to datapath commands
  typedef struct packed {
    logic              latch;
    logic              restart;
    logic              gen_start;
    logic              round_step;
    logic              diag;
    logic [SLOT_W-1:0] slot;
    logic              final_add;
    logic              emit;
    logic              emit_live;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic blk_rdy;
  } sts_t;

  function automatic word_t rotl(word_t v, int s);
    return (v << s) | (v >> (WORD_W - s));
  endfunction

  function automatic qr_t quarter(qr_t q);
    qr_t r;
    r = q;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, ROT_A);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, ROT_B);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, ROT_C);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, ROT_D);
    return r;
  endfunction

  // quarter-round lanes that run side by side in one round slot
  function automatic int qr_lanes(int units);
    if (units >= 4) return 4;
    else if (units >= 2) return 2;
    else return 1;
  endfunction

endpackage

[design/chacha20_stream_cipher.sv]
// chacha20_stream_cipher: top level, xors 32-bit data words with the chacha20 keystream
// depends on cc20_pkg, cc20_ctrl, cc20_datapath
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------
//   cfg      | cfg_we                 | cfg_index, cfg_data
//   in       | in_valid / in_ready    | in_data_in, in_byte_count, in_restart
//   out      | out_valid / out_ready  | out_data_out, out_byte_count_out, out_block_end
//
// a request within a ready keystream block goes straight to the output
// register when that register is free; a request that needs a new block
// (first of a block or a restart) goes through the round sequencer: init,
// the round slots on the quarter-round lanes, final add, then output
// reset: synchronous active-low rst_n clears control and config registers
// a stalled output holds its result while one more request is taken in
module chacha20_stream_cipher #(
  parameter int QUARTER_ROUND_UNITS = cc20_pkg::QR_UNITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cc20_pkg::WORD_W-1:0]     in_data_in,
  input  logic [cc20_pkg::CNT_W-1:0]      in_byte_count,
  input  logic                            in_restart,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cc20_pkg::WORD_W-1:0]     out_data_out,
  output logic [cc20_pkg::CNT_W-1:0]      out_byte_count_out,
  output logic                            out_block_end
);
  import cc20_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: intake, round slots, final add, output register valid
  cc20_ctrl #(
    .QUARTER_ROUND_UNITS(QUARTER_ROUND_UNITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: key/nonce/counter, 16-word round state, keystream block, output payload
  cc20_datapath #(
    .QUARTER_ROUND_UNITS(QUARTER_ROUND_UNITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_data_in         (in_data_in),
    .in_byte_count      (in_byte_count),
    .cmd                (cmd),
    .sts                (sts),
    .out_data_out       (out_data_out),
    .out_byte_count_out (out_byte_count_out),
    .out_block_end      (out_block_end)
  );

endmodule

[design/cc20_ctrl.sv]
// cc20_ctrl: sequencer for request intake, block generation and result output
// depends on cc20_pkg
module cc20_ctrl #(
  parameter int QUARTER_ROUND_UNITS = cc20_pkg::QR_UNITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_restart,
  output logic            out_valid,
  input  logic            out_ready,
  input  cc20_pkg::sts_t  sts,
  output cc20_pkg::cmd_t  cmd
);
  import cc20_pkg::*;

  localparam int LANES  = qr_lanes(QUARTER_ROUND_UNITS);
  localparam int STEPS  = 4 / LANES;
  localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int RND_W  = $clog2(ROUNDS);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_RND, S_ADD, S_OUT} state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;
  logic              in_acc;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    rnd_nxt       = rnd_r;
    cmd           = '0;
    cmd.diag      = rnd_r[0];
    cmd.slot      = SLOT_W'(step_r);
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.latch = 1'b1;
          if (in_restart) begin
            cmd.restart = 1'b1;
            state_nxt   = S_INIT;
          end else if (!sts.blk_rdy) begin
            state_nxt = S_INIT;
          end else if (out_free) begin
            cmd.emit      = 1'b1;
            cmd.emit_live = 1'b1;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_INIT: begin
        cmd.gen_start = 1'b1;
        step_nxt      = '0;
        rnd_nxt       = '0;
        state_nxt     = S_RND;
      end
      S_RND: begin
        cmd.round_step = 1'b1;
        if (step_r == STEP_W'(STEPS - 1)) begin
          step_nxt = '0;
          if (rnd_r == RND_W'(ROUNDS - 1)) state_nxt = S_ADD;
          else rnd_nxt = rnd_r + 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_ADD: begin
        cmd.final_add = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      rnd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      rnd_r       <= rnd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[design/cc20_datapath.sv]
// cc20_datapath: config registers, round state, quarter-round lanes,
// keystream block and output register
// depends on cc20_pkg
module cc20_datapath #(
  parameter int QUARTER_ROUND_UNITS = cc20_pkg::QR_UNITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [cc20_pkg::WORD_W-1:0]     in_data_in,
  input  logic [cc20_pkg::CNT_W-1:0]      in_byte_count,
  input  cc20_pkg::cmd_t                  cmd,
  output cc20_pkg::sts_t                  sts,
  output logic [cc20_pkg::WORD_W-1:0]     out_data_out,
  output logic [cc20_pkg::CNT_W-1:0]      out_byte_count_out,
  output logic                            out_block_end
);
  import cc20_pkg::*;

  localparam int LANES = qr_lanes(QUARTER_ROUND_UNITS);

  word_t key_r [8];
  word_t key_nxt [8];
  word_t nonce_r [3];
  word_t nonce_nxt [3];
  word_t init_ctr_r, init_ctr_nxt;
  word_t ctr_r, ctr_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic blk_rdy_r, blk_rdy_nxt;

  word_t w_r [WORDS];
  word_t w_nxt [WORDS];
  word_t ws_r [WORDS];
  word_t ws_nxt [WORDS];
  word_t ks_r [WORDS];
  word_t ks_nxt [WORDS];
  word_t init_st [WORDS];

  word_t item_data_r, item_data_nxt;
  logic [CNT_W-1:0] item_cnt_r, item_cnt_nxt;
  word_t out_data_r, out_data_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic out_end_r, out_end_nxt;

  logic [POS_W-1:0] idx_a [LANES];
  logic [POS_W-1:0] idx_b [LANES];
  logic [POS_W-1:0] idx_c [LANES];
  logic [POS_W-1:0] idx_d [LANES];
  qr_t q_out [LANES];

  word_t src_data, ks_word, mask;
  logic [CNT_W-1:0] src_cnt;

  assign sts.blk_rdy        = blk_rdy_r;
  assign out_data_out       = out_data_r;
  assign out_byte_count_out = out_cnt_r;
  assign out_block_end      = out_end_r;

  // initial block state from constants, key, counter and nonce
  always_comb begin
    init_st[0] = SIGMA0;
    init_st[1] = SIGMA1;
    init_st[2] = SIGMA2;
    init_st[3] = SIGMA3;
    for (int i = 0; i < 8; i++) init_st[4 + i] = key_r[i];
    init_st[12] = ctr_r;
    for (int i = 0; i < 3; i++) init_st[13 + i] = nonce_r[i];
  end

  // lane word selection: column or diagonal pattern
  always_comb begin
    logic [1:0] j;
    qr_t q_in;
    for (int l = 0; l < LANES; l++) begin
      j = 2'(int'(cmd.slot) * LANES + l);
      idx_a[l] = {2'b00, j};
      idx_b[l] = {2'b01, cmd.diag ? j + 2'd1 : j};
      idx_c[l] = {2'b10, cmd.diag ? j + 2'd2 : j};
      idx_d[l] = {2'b11, cmd.diag ? j + 2'd3 : j};
      q_in.a = w_r[idx_a[l]];
      q_in.b = w_r[idx_b[l]];
      q_in.c = w_r[idx_c[l]];
      q_in.d = w_r[idx_d[l]];
      q_out[l] = quarter(q_in);
    end
  end

  always_comb begin
    key_nxt      = key_r;
    nonce_nxt    = nonce_r;
    init_ctr_nxt = init_ctr_r;
    ctr_nxt      = ctr_r;
    pos_nxt      = pos_r;
    blk_rdy_nxt  = blk_rdy_r;
    w_nxt        = w_r;
    ws_nxt       = ws_r;
    ks_nxt       = ks_r;
    item_data_nxt = item_data_r;
    item_cnt_nxt  = item_cnt_r;
    out_data_nxt  = out_data_r;
    out_cnt_nxt   = out_cnt_r;
    out_end_nxt   = out_end_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_0: begin
          key_nxt[0] = cfg_data[31:0];
          key_nxt[1] = cfg_data[63:32];
        end
        CFG_KEY_1: begin
          key_nxt[2] = cfg_data[31:0];
          key_nxt[3] = cfg_data[63:32];
        end
        CFG_KEY_2: begin
          key_nxt[4] = cfg_data[31:0];
          key_nxt[5] = cfg_data[63:32];
        end
        CFG_KEY_3: begin
          key_nxt[6] = cfg_data[31:0];
          key_nxt[7] = cfg_data[63:32];
        end
        CFG_NONCE_0: begin
          nonce_nxt[0] = cfg_data[31:0];
          nonce_nxt[1] = cfg_data[63:32];
        end
        CFG_NONCE_1:  nonce_nxt[2] = cfg_data[31:0];
        CFG_INIT_CTR: init_ctr_nxt = cfg_data[31:0];
        default: ;
      endcase
    end

    if (cmd.latch) begin
      item_data_nxt = in_data_in;
      item_cnt_nxt  = in_byte_count;
    end

    if (cmd.restart) begin
      ctr_nxt     = init_ctr_r;
      pos_nxt     = '0;
      blk_rdy_nxt = 1'b0;
    end

    if (cmd.gen_start) begin
      w_nxt  = init_st;
      ws_nxt = init_st;
    end else if (cmd.round_step) begin
      for (int k = 0; k < WORDS; k++) begin
        for (int l = 0; l < LANES; l++) begin
          if (idx_a[l] == POS_W'(k)) w_nxt[k] = q_out[l].a;
          if (idx_b[l] == POS_W'(k)) w_nxt[k] = q_out[l].b;
          if (idx_c[l] == POS_W'(k)) w_nxt[k] = q_out[l].c;
          if (idx_d[l] == POS_W'(k)) w_nxt[k] = q_out[l].d;
        end
      end
    end

    if (cmd.final_add) begin
      for (int k = 0; k < WORDS; k++) ks_nxt[k] = w_r[k] + ws_r[k];
      blk_rdy_nxt = 1'b1;
    end

    src_data = cmd.emit_live ? in_data_in : item_data_r;
    src_cnt  = cmd.emit_live ? in_byte_count : item_cnt_r;
    ks_word  = ks_r[pos_r];
    case (src_cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase

    if (cmd.emit) begin
      out_data_nxt = (src_data ^ ks_word) & mask;
      out_cnt_nxt  = src_cnt;
      out_end_nxt  = (pos_r == POS_LAST);
      pos_nxt      = pos_r + 1'b1;
      if (pos_r == POS_LAST) begin
        ctr_nxt     = ctr_r + 1'b1;
        blk_rdy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) key_r[i] <= '0;
      for (int i = 0; i < 3; i++) nonce_r[i] <= '0;
      init_ctr_r <= '0;
      ctr_r      <= '0;
      pos_r      <= '0;
      blk_rdy_r  <= 1'b0;
    end else begin
      key_r      <= key_nxt;
      nonce_r    <= nonce_nxt;
      init_ctr_r <= init_ctr_nxt;
      ctr_r      <= ctr_nxt;
      pos_r      <= pos_nxt;
      blk_rdy_r  <= blk_rdy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r         <= w_nxt;
    ws_r        <= ws_nxt;
    ks_r        <= ks_nxt;
    item_data_r <= item_data_nxt;
    item_cnt_r  <= item_cnt_nxt;
    out_data_r  <= out_data_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule

[design/cc20_checker.sv]
// cc20_checker: port-level assertions for the chacha20 stream cipher
// depends on cc20_pkg; bound to chacha20_stream_cipher
module cc20_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [cc20_pkg::WORD_W-1:0]     out_data_out,
  input logic [cc20_pkg::CNT_W-1:0]      out_byte_count_out,
  input logic                            out_block_end
);
  import cc20_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data_out) && $stable(out_byte_count_out)
      && $stable(out_block_end))
    else $error("result payload changed while stalled");

  // single-byte words carry no high bytes
  a_mask_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count_out == 3'd1 |-> out_data_out[31:8] == 24'd0)
    else $error("unused bytes not masked");

  // zero byte count gives zero data
  a_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_count_out == 3'd0 |-> out_data_out == '0)
    else $error("zero-length word not zero");

  // after reset nothing is pending and a request can be taken
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (.*);
